/* sv/ces_pkg.sv */
// Shared types, constants and calibration tables for the calorimeter event selector.
package ces_pkg;

  // Operation codes carried by each input beat
  typedef enum logic {
    OP_TOWER = 1'b0,
    OP_CLOSE = 1'b1
  } op_t;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BEAM_SPOT   = 2'd0,
    CFG_MATCH_LIMIT = 2'd1,
    CFG_PRESHOWER   = 2'd2,
    CFG_MUON        = 2'd3
  } cfg_idx_t;

  localparam int CfgDataW = 12;

  // Configuration reset values
  localparam logic [3:0]  BeamSpotRst   = 4'd1;
  localparam logic [11:0] MatchLimitRst = 12'd256;
  localparam logic [11:0] PreshowerRst  = 12'd424;
  localparam logic [11:0] MuonRst       = 12'd38;

  // Geometry in 1/64 mm
  localparam int GridOrigin  = 1600;
  localparam int CellLowEdge = -320;
  localparam int DivFiveRecip = 13108;   // floor(x/5) = (x*13108) >> 16 for x < 1024

  localparam logic [12:0] OfsCol0 = 13'd0;
  localparam logic [12:0] OfsCol1 = 13'd1555;
  localparam logic [12:0] OfsCol2 = 13'd3104;
  localparam logic [12:0] OfsCol3 = 13'd4659;
  localparam logic [12:0] OfsCol4 = 13'd6208;
  localparam logic [11:0] OfsRow0 = 12'd3200;
  localparam logic [11:0] OfsRow1 = 12'd1600;
  localparam logic [11:0] OfsRow2 = 12'd0;

  localparam int RomTowers = 36;
  localparam int CoefW     = 24;
  localparam int MagW      = 23;
  localparam int ProdW     = MagW + CoefW;
  localparam int TermW     = ProdW - 21;   // product bits 46:21, bit 21 is the rounding bit

  // Per-stage load strobes from the top level
  typedef struct packed {
    logic ld1;     // input beat captured
    logic ld2;     // stage one moves to stage two
    logic adv3;    // stage two retires into the accumulators / result register
    logic close3;  // retiring item is an event close
  } stage_ctl_t;

  typedef struct packed {
    logic [12:0] x;
    logic [11:0] y;
  } beam_ofs_t;

  typedef struct packed {
    logic       above_low;  // v > -320
    logic [6:0] q;          // v / 320, zero for negative v
  } bin_t;

  // Cherenkov coefficient: round(n * scale * 2^32 / 1e6) style fixed conversion
  function automatic logic [CoefW-1:0] cer_coef(input logic [20:0] n);
    logic [63:0] t;
    t = ({43'd0, n} * 64'd402653184 + 64'd48851562) / 64'd97703125;
    return t[CoefW-1:0];
  endfunction

  // Scintillation coefficient
  function automatic logic [CoefW-1:0] sci_coef(input logic [20:0] n);
    logic [63:0] t;
    t = ({43'd0, n} * 64'd402653184 + 64'd47398437) / 64'd94796875;
    return t[CoefW-1:0];
  endfunction

  localparam logic [CoefW-1:0] CerRom [RomTowers] = '{
    cer_coef(21'd1203555), cer_coef(21'd1212408), cer_coef(21'd1243669), cer_coef(21'd1204270),
    cer_coef(21'd1114422), cer_coef(21'd1210115), cer_coef(21'd1134603), cer_coef(21'd1228336),
    cer_coef(21'd1167599), cer_coef(21'd1298819), cer_coef(21'd1253319), cer_coef(21'd1245581),
    cer_coef(21'd1194330), cer_coef(21'd1002412), cer_coef(21'd1195593), cer_coef(21'd1178153),
    cer_coef(21'd1322633), cer_coef(21'd1207860), cer_coef(21'd1544522), cer_coef(21'd1155995),
    cer_coef(21'd1242049), cer_coef(21'd1142602), cer_coef(21'd1283866), cer_coef(21'd1343688),
    cer_coef(21'd1249390), cer_coef(21'd1223514), cer_coef(21'd1252899), cer_coef(21'd1233478),
    cer_coef(21'd1276618), cer_coef(21'd1222038), cer_coef(21'd1211442), cer_coef(21'd1226694),
    cer_coef(21'd1239990), cer_coef(21'd1236395), cer_coef(21'd1227406), cer_coef(21'd1174254)
  };

  localparam logic [CoefW-1:0] SciRom [RomTowers] = '{
    sci_coef(21'd608168), sci_coef(21'd599951), sci_coef(21'd632579), sci_coef(21'd637480),
    sci_coef(21'd603563), sci_coef(21'd601509), sci_coef(21'd624896), sci_coef(21'd654066),
    sci_coef(21'd604899), sci_coef(21'd624518), sci_coef(21'd621517), sci_coef(21'd645067),
    sci_coef(21'd631232), sci_coef(21'd598297), sci_coef(21'd617460), sci_coef(21'd638033),
    sci_coef(21'd628109), sci_coef(21'd577394), sci_coef(21'd777161), sci_coef(21'd660589),
    sci_coef(21'd642289), sci_coef(21'd637514), sci_coef(21'd651367), sci_coef(21'd665772),
    sci_coef(21'd631831), sci_coef(21'd611742), sci_coef(21'd592046), sci_coef(21'd641848),
    sci_coef(21'd625958), sci_coef(21'd599988), sci_coef(21'd612211), sci_coef(21'd637865),
    sci_coef(21'd631297), sci_coef(21'd614992), sci_coef(21'd635913), sci_coef(21'd655751)
  };

  // Beam spot offset; case zero behaves as case one
  function automatic beam_ofs_t beam_offset(input logic [3:0] spot);
    logic [3:0] c;
    logic [3:0] col;
    beam_ofs_t  o;
    c = (spot == 4'd0) ? 4'd0 : spot - 4'd1;
    case (c) inside
      [4'd0:4'd4]: begin
        o.y = OfsRow0;
        col = c;
      end
      [4'd5:4'd9]: begin
        o.y = OfsRow1;
        col = c - 4'd5;
      end
      default: begin
        o.y = OfsRow2;
        col = c - 4'd10;
      end
    endcase
    case (col)
      4'd0:    o.x = OfsCol0;
      4'd1:    o.x = OfsCol1;
      4'd2:    o.x = OfsCol2;
      4'd3:    o.x = OfsCol3;
      default: o.x = OfsCol4;
    endcase
    return o;
  endfunction

  // Cell index of a shifted coordinate, truncating toward zero
  function automatic bin_t bin_coord(input logic [16:0] v);
    logic [23:0] p;
    bin_t        b;
    p = {14'd0, v[15:6]} * 24'(DivFiveRecip);
    b.above_low = ($signed(v) > 17'(CellLowEdge)) ? 1'b1 : 1'b0;
    b.q = v[16] ? 7'd0 : p[22:16];
    return b;
  endfunction

endpackage

/* sv/ces_tower_path.sv */
// Calibration lookup and per-tower energy multiply, two register stages.
module ces_tower_path #(
  parameter int TOWER_COUNT = 36
) (
  input  logic                       clk,
  input  ces_pkg::stage_ctl_t        ctl,
  input  logic                       in_operation,
  input  logic [5:0]                 in_tower_index,
  input  logic signed [23:0]         in_ceren_adc,
  input  logic signed [23:0]         in_scint_adc,
  output logic [ces_pkg::TermW-1:0]  ceren_term_r,
  output logic [ces_pkg::TermW-1:0]  scint_term_r
);

  logic                        tower_ok;
  logic [5:0]                  rom_addr;
  logic [ces_pkg::MagW-1:0]    ceren_mag, scint_mag;
  logic [ces_pkg::MagW-1:0]    ceren_mag_r, scint_mag_r;
  logic [ces_pkg::CoefW-1:0]   ceren_coef_r, scint_coef_r;
  logic [ces_pkg::ProdW-1:0]   ceren_prod, scint_prod;

  // Qualify the beat: tower sample with an index inside the table
  assign tower_ok = (in_operation == ces_pkg::OP_TOWER) &&
                    ({1'b0, in_tower_index} < 7'(TOWER_COUNT)) &&
                    ({1'b0, in_tower_index} < 7'(ces_pkg::RomTowers));
  assign rom_addr = tower_ok ? in_tower_index : 6'd0;

  // Drop non-positive samples
  assign ceren_mag = (tower_ok && !in_ceren_adc[23] && (in_ceren_adc != 24'sd0)) ?
                     in_ceren_adc[22:0] : '0;
  assign scint_mag = (tower_ok && !in_scint_adc[23] && (in_scint_adc != 24'sd0)) ?
                     in_scint_adc[22:0] : '0;

  // Stage one: hold sample magnitudes and coefficients
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      ceren_mag_r  <= ceren_mag;
      scint_mag_r  <= scint_mag;
      ceren_coef_r <= ces_pkg::CerRom[rom_addr];
      scint_coef_r <= ces_pkg::SciRom[rom_addr];
    end
  end

  assign ceren_prod = ces_pkg::ProdW'(ceren_mag_r) * ces_pkg::ProdW'(ceren_coef_r);
  assign scint_prod = ces_pkg::ProdW'(scint_mag_r) * ces_pkg::ProdW'(scint_coef_r);

  // Stage two: keep the product bits above the rounding point
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      ceren_term_r <= ceren_prod[ces_pkg::ProdW-1:21];
      scint_term_r <= scint_prod[ces_pkg::ProdW-1:21];
    end
  end

endmodule

/* sv/ces_track_path.sv */
// Chamber match, counter cuts and grid binning, two register stages.
module ces_track_path #(
  parameter int GRID_COLUMNS = 30,
  parameter int GRID_ROWS    = 20
) (
  input  logic                clk,
  input  ces_pkg::stage_ctl_t ctl,
  input  logic [3:0]          beam_spot_r,
  input  logic [11:0]         match_limit_r,
  input  logic [11:0]         preshower_min_r,
  input  logic [11:0]         muon_max_r,
  input  logic signed [15:0]  in_chamber1_x,
  input  logic signed [15:0]  in_chamber1_y,
  input  logic signed [15:0]  in_chamber2_x,
  input  logic signed [15:0]  in_chamber2_y,
  input  logic [11:0]         in_preshower_peak,
  input  logic [11:0]         in_muon_peak,
  output logic                passed_r,
  output logic                in_grid_r,
  output logic [4:0]          cell_x_r,
  output logic [4:0]          cell_y_r
);

  ces_pkg::beam_ofs_t ofs;
  logic [16:0]        v1x, v1y, v2x, v2y;
  logic [16:0]        v1x_r, v1y_r, v2x_r, v2y_r;
  logic [15:0]        c1x_r, c1y_r, c2x_r, c2y_r;
  logic [11:0]        pre_r, muon_r;
  logic [16:0]        dx, dy, adx, ady;
  ces_pkg::bin_t      b1x, b1y, b2x, b2y;
  logic               ok1x, ok1y, ok2x, ok2y, grid, pass;

  // Shift positions by the beam spot and grid origin
  assign ofs = ces_pkg::beam_offset(beam_spot_r);
  assign v1x = {in_chamber1_x[15], in_chamber1_x} + {4'd0, ofs.x} + 17'(ces_pkg::GridOrigin);
  assign v1y = {in_chamber1_y[15], in_chamber1_y} + {5'd0, ofs.y} + 17'(ces_pkg::GridOrigin);
  assign v2x = {in_chamber2_x[15], in_chamber2_x} + {4'd0, ofs.x} + 17'(ces_pkg::GridOrigin);
  assign v2y = {in_chamber2_y[15], in_chamber2_y} + {5'd0, ofs.y} + 17'(ces_pkg::GridOrigin);

  // Stage one: hold shifted and raw positions and counter peaks
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      v1x_r  <= v1x;
      v1y_r  <= v1y;
      v2x_r  <= v2x;
      v2y_r  <= v2y;
      c1x_r  <= in_chamber1_x;
      c1y_r  <= in_chamber1_y;
      c2x_r  <= in_chamber2_x;
      c2y_r  <= in_chamber2_y;
      pre_r  <= in_preshower_peak;
      muon_r <= in_muon_peak;
    end
  end

  // Chamber match and counter cuts
  assign dx   = {c1x_r[15], c1x_r} - {c2x_r[15], c2x_r};
  assign dy   = {c1y_r[15], c1y_r} - {c2y_r[15], c2y_r};
  assign adx  = dx[16] ? (17'd0 - dx) : dx;
  assign ady  = dy[16] ? (17'd0 - dy) : dy;
  assign pass = (adx <= {5'd0, match_limit_r}) && (ady <= {5'd0, match_limit_r}) &&
                (pre_r >= preshower_min_r) && (muon_r <= muon_max_r);

  // Bin all four coordinates
  assign b1x  = ces_pkg::bin_coord(v1x_r);
  assign b1y  = ces_pkg::bin_coord(v1y_r);
  assign b2x  = ces_pkg::bin_coord(v2x_r);
  assign b2y  = ces_pkg::bin_coord(v2y_r);
  assign ok1x = b1x.above_low && (b1x.q < 7'(GRID_COLUMNS));
  assign ok1y = b1y.above_low && (b1y.q < 7'(GRID_ROWS));
  assign ok2x = b2x.above_low && (b2x.q < 7'(GRID_COLUMNS));
  assign ok2y = b2y.above_low && (b2y.q < 7'(GRID_ROWS));
  assign grid = ok1x && ok1y && ok2x && ok2y;

  // Stage two: hold the event verdict and chamber two cell
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      passed_r  <= pass;
      in_grid_r <= grid;
      cell_x_r  <= grid ? b2x.q[4:0] : 5'd0;
      cell_y_r  <= grid ? b2y.q[4:0] : 5'd0;
    end
  end

endmodule

/* sv/ces_energy_acc.sv */
// Saturating energy accumulators and the energy half of the result register.
module ces_energy_acc (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ces_pkg::stage_ctl_t       ctl,
  input  logic [ces_pkg::TermW-1:0] ceren_term_r,
  input  logic [ces_pkg::TermW-1:0] scint_term_r,
  output logic [31:0]               energy_ceren_r,
  output logic [31:0]               energy_scint_r
);

  logic [31:0] ceren_acc_r, ceren_acc_nxt;
  logic [31:0] scint_acc_r, scint_acc_nxt;
  logic [32:0] ceren_sum, scint_sum;

  // Add the rounded term: upper bits plus the rounding bit as carry
  assign ceren_sum = {1'b0, ceren_acc_r} + 33'(ceren_term_r[ces_pkg::TermW-1:1]) +
                     33'(ceren_term_r[0]);
  assign scint_sum = {1'b0, scint_acc_r} + 33'(scint_term_r[ces_pkg::TermW-1:1]) +
                     33'(scint_term_r[0]);

  // Saturate on tower beats, clear on event close
  always_comb begin
    ceren_acc_nxt = ceren_acc_r;
    scint_acc_nxt = scint_acc_r;
    if (ctl.adv3) begin
      if (ctl.close3) begin
        ceren_acc_nxt = '0;
        scint_acc_nxt = '0;
      end else begin
        ceren_acc_nxt = ceren_sum[32] ? 32'hFFFF_FFFF : ceren_sum[31:0];
        scint_acc_nxt = scint_sum[32] ? 32'hFFFF_FFFF : scint_sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceren_acc_r <= '0;
      scint_acc_r <= '0;
    end else begin
      ceren_acc_r <= ceren_acc_nxt;
      scint_acc_r <= scint_acc_nxt;
    end
  end

  // Latch the sums into the result register on event close
  always_ff @(posedge clk) begin
    if (ctl.adv3 && ctl.close3) begin
      energy_ceren_r <= ceren_acc_r;
      energy_scint_r <= scint_acc_r;
    end
  end

endmodule

/* sv/calorimeter_event_selector.sv */
// Top level: handshake, configuration registers and result register of the event selector.
// Path: an event-close beat is captured at the accepting edge, then passes the
// multiply/binning stage and the accumulate/result register; its result is held up only while
// out_ready is low.
// Throughput: one beat per cycle unless an event close waits in stage two behind a stalled
// result; tower beats keep flowing past a waiting result, set by the single multiply per channel in stage two.
module calorimeter_event_selector #(
  parameter int TOWER_COUNT  = 36,
  parameter int GRID_COLUMNS = 30,
  parameter int GRID_ROWS    = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [5:0]                   in_tower_index,
  input  logic signed [23:0]           in_ceren_adc,
  input  logic signed [23:0]           in_scint_adc,
  input  logic signed [15:0]           in_chamber1_x,
  input  logic signed [15:0]           in_chamber1_y,
  input  logic signed [15:0]           in_chamber2_x,
  input  logic signed [15:0]           in_chamber2_y,
  input  logic [11:0]                  in_preshower_peak,
  input  logic [11:0]                  in_muon_peak,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_passed_cuts,
  output logic                         out_in_grid,
  output logic [4:0]                   out_cell_x,
  output logic [4:0]                   out_cell_y,
  output logic [31:0]                  out_energy_ceren,
  output logic [31:0]                  out_energy_scint,
  input  logic                         cfg_we,
  input  logic [ces_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ces_pkg::CfgDataW-1:0] cfg_wdata
);

  // Reset (synchronous, rst_n low): accumulators cleared, pipeline emptied, registers to defaults.
  ces_pkg::stage_ctl_t        ctl;
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       s2_valid_r, s2_valid_nxt;
  logic                       s1_close_r, s2_close_r;
  logic                       out_valid_r, out_valid_nxt;
  logic                       s2_free;
  logic [3:0]                 beam_spot_r;
  logic [11:0]                match_limit_r, preshower_min_r, muon_max_r;
  logic [ces_pkg::TermW-1:0]  ceren_term_r, scint_term_r;
  logic                       passed_r, in_grid_r;
  logic [4:0]                 cell_x_r, cell_y_r;
  logic                       out_passed_r, out_in_grid_r;
  logic [4:0]                 out_cell_x_r, out_cell_y_r;
  logic [31:0]                energy_ceren_r, energy_scint_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_spot_r     <= ces_pkg::BeamSpotRst;
      match_limit_r   <= ces_pkg::MatchLimitRst;
      preshower_min_r <= ces_pkg::PreshowerRst;
      muon_max_r      <= ces_pkg::MuonRst;
    end else if (cfg_we) begin
      case (cfg_index)
        ces_pkg::CFG_BEAM_SPOT:   beam_spot_r     <= cfg_wdata[3:0];
        ces_pkg::CFG_MATCH_LIMIT: match_limit_r   <= cfg_wdata;
        ces_pkg::CFG_PRESHOWER:   preshower_min_r <= cfg_wdata;
        ces_pkg::CFG_MUON:        muon_max_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage advance: tower beats retire freely, close beats wait for the result register
  assign ctl.adv3   = s2_valid_r && (!s2_close_r || !out_valid_r || out_ready);
  assign ctl.close3 = s2_close_r;
  assign s2_free    = !s2_valid_r || ctl.adv3;
  assign ctl.ld2    = s1_valid_r && s2_free;
  assign in_ready   = !s1_valid_r || ctl.ld2;
  assign ctl.ld1    = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = ctl.ld1 ? 1'b1 : (ctl.ld2 ? 1'b0 : s1_valid_r);
    s2_valid_nxt = ctl.ld2 ? 1'b1 : (ctl.adv3 ? 1'b0 : s2_valid_r);
    if (ctl.adv3 && ctl.close3) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Track the operation of each stage
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      s1_close_r <= (in_operation == ces_pkg::OP_CLOSE);
    end
    if (ctl.ld2) begin
      s2_close_r <= s1_close_r;
    end
  end

  ces_tower_path #(
    .TOWER_COUNT (TOWER_COUNT)
  ) u_tower (
    .clk            (clk),
    .ctl            (ctl),
    .in_operation   (in_operation),
    .in_tower_index (in_tower_index),
    .in_ceren_adc   (in_ceren_adc),
    .in_scint_adc   (in_scint_adc),
    .ceren_term_r   (ceren_term_r),
    .scint_term_r   (scint_term_r)
  );

  ces_track_path #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_track (
    .clk               (clk),
    .ctl               (ctl),
    .beam_spot_r       (beam_spot_r),
    .match_limit_r     (match_limit_r),
    .preshower_min_r   (preshower_min_r),
    .muon_max_r        (muon_max_r),
    .in_chamber1_x     (in_chamber1_x),
    .in_chamber1_y     (in_chamber1_y),
    .in_chamber2_x     (in_chamber2_x),
    .in_chamber2_y     (in_chamber2_y),
    .in_preshower_peak (in_preshower_peak),
    .in_muon_peak      (in_muon_peak),
    .passed_r          (passed_r),
    .in_grid_r         (in_grid_r),
    .cell_x_r          (cell_x_r),
    .cell_y_r          (cell_y_r)
  );

  ces_energy_acc u_acc (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .ceren_term_r   (ceren_term_r),
    .scint_term_r   (scint_term_r),
    .energy_ceren_r (energy_ceren_r),
    .energy_scint_r (energy_scint_r)
  );

  // Result register: event verdict and cell
  always_ff @(posedge clk) begin
    if (ctl.adv3 && ctl.close3) begin
      out_passed_r  <= passed_r;
      out_in_grid_r <= in_grid_r;
      out_cell_x_r  <= cell_x_r;
      out_cell_y_r  <= cell_y_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_passed_cuts  = out_passed_r;
  assign out_in_grid      = out_in_grid_r;
  assign out_cell_x       = out_cell_x_r;
  assign out_cell_y       = out_cell_y_r;
  assign out_energy_ceren = energy_ceren_r;
  assign out_energy_scint = energy_scint_r;

endmodule

/* sv/ces_checker.sv */
// Port-level checks on the event selector result channel, bound to the top level.
module ces_checker #(
  parameter int GRID_COLUMNS = 30,
  parameter int GRID_ROWS    = 20
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_passed_cuts,
  input logic        out_in_grid,
  input logic [4:0]  out_cell_x,
  input logic [4:0]  out_cell_y,
  input logic [31:0] out_energy_ceren,
  input logic [31:0] out_energy_scint
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_passed_cuts) &&
    $stable(out_in_grid) && $stable(out_cell_x) && $stable(out_cell_y) &&
    $stable(out_energy_ceren) && $stable(out_energy_scint))
    else $error("result beat changed while stalled");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Off-grid events report cell zero
  a_off_grid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_grid |-> out_cell_x == 5'd0 && out_cell_y == 5'd0)
    else $error("off-grid event with nonzero cell");

  // On-grid cells stay inside the grid
  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_grid |->
    32'(out_cell_x) < GRID_COLUMNS && 32'(out_cell_y) < GRID_ROWS)
    else $error("cell outside the grid");

endmodule

bind calorimeter_event_selector ces_checker #(
  .GRID_COLUMNS (GRID_COLUMNS),
  .GRID_ROWS    (GRID_ROWS)
) u_ces_checker (.*);

/* sim/tb_calorimeter_event_selector.sv */
// Self-checking testbench for the calorimeter event selector: directed and random beats.
module tb_calorimeter_event_selector;

  localparam int NumTowers    = 36;
  localparam int GridCols     = 30;
  localparam int GridRows     = 20;
  localparam int CellPitch    = 320;
  localparam int SettleCycles = 8;
  localparam int MaxAdc       = 8388607;

  typedef struct {
    ces_pkg::op_t       op;
    logic [5:0]         tower;
    logic signed [23:0] ceren;
    logic signed [23:0] scint;
    logic signed [15:0] c1x;
    logic signed [15:0] c1y;
    logic signed [15:0] c2x;
    logic signed [15:0] c2y;
    logic [11:0]        preshower;
    logic [11:0]        muon;
  } beat_t;

  typedef struct {
    logic        passed;
    logic        in_grid;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic [31:0] e_ceren;
    logic [31:0] e_scint;
  } selection_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_operation = 1'b0;
  logic [5:0]                    in_tower_index = '0;
  logic signed [23:0]            in_ceren_adc = '0;
  logic signed [23:0]            in_scint_adc = '0;
  logic signed [15:0]            in_chamber1_x = '0;
  logic signed [15:0]            in_chamber1_y = '0;
  logic signed [15:0]            in_chamber2_x = '0;
  logic signed [15:0]            in_chamber2_y = '0;
  logic [11:0]                   in_preshower_peak = '0;
  logic [11:0]                   in_muon_peak = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_passed_cuts;
  logic                          out_in_grid;
  logic [4:0]                    out_cell_x;
  logic [4:0]                    out_cell_y;
  logic [31:0]                   out_energy_ceren;
  logic [31:0]                   out_energy_scint;
  logic                          cfg_we = 1'b0;
  logic [ces_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic [ces_pkg::CfgDataW-1:0]  cfg_wdata = '0;

  // Raw per-channel calibration numbers, scaled into Q2.22 on lookup
  int unsigned cer_raw [NumTowers] = '{
    1203555, 1212408, 1243669, 1204270, 1114422, 1210115, 1134603, 1228336,
    1167599, 1298819, 1253319, 1245581, 1194330, 1002412, 1195593, 1178153,
    1322633, 1207860, 1544522, 1155995, 1242049, 1142602, 1283866, 1343688,
    1249390, 1223514, 1252899, 1233478, 1276618, 1222038, 1211442, 1226694,
    1239990, 1236395, 1227406, 1174254
  };
  int unsigned sci_raw [NumTowers] = '{
    608168, 599951, 632579, 637480, 603563, 601509, 624896, 654066,
    604899, 624518, 621517, 645067, 631232, 598297, 617460, 638033,
    628109, 577394, 777161, 660589, 642289, 637514, 651367, 665772,
    631831, 611742, 592046, 641848, 625958, 599988, 612211, 637865,
    631297, 614992, 635913, 655751
  };

  // Beam spot offsets in 1/64 mm
  int col_ofs [5] = '{0, 1555, 3104, 4659, 6208};
  int row_ofs [3] = '{3200, 1600, 0};

  // Predictor state and its copy of the registers
  logic [31:0] ceren_total = '0;
  logic [31:0] scint_total = '0;
  logic [3:0]  spot_case = 4'd1;
  int          match_limit = 256;
  int          pre_min = 424;
  int          mu_max = 38;

  selection_t  expected_selections [$];
  int          mismatches = 0;
  int          accepted_items = 0;
  int          burst_left = 0;
  int          ready_mode = 0;
  int          ready_left = 0;

  calorimeter_event_selector u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_tower_index    (in_tower_index),
    .in_ceren_adc      (in_ceren_adc),
    .in_scint_adc      (in_scint_adc),
    .in_chamber1_x     (in_chamber1_x),
    .in_chamber1_y     (in_chamber1_y),
    .in_chamber2_x     (in_chamber2_x),
    .in_chamber2_y     (in_chamber2_y),
    .in_preshower_peak (in_preshower_peak),
    .in_muon_peak      (in_muon_peak),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_passed_cuts   (out_passed_cuts),
    .out_in_grid       (out_in_grid),
    .out_cell_x        (out_cell_x),
    .out_cell_y        (out_cell_y),
    .out_energy_ceren  (out_energy_ceren),
    .out_energy_scint  (out_energy_scint),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [23:0] calib(bit scint_side, int idx);
    logic [63:0] n;
    logic [63:0] k;
    if (scint_side) begin
      n = 64'(sci_raw[idx]);
      k = (n * 64'd402653184 + 64'd47398437) / 64'd94796875;
    end else begin
      n = 64'(cer_raw[idx]);
      k = (n * 64'd402653184 + 64'd48851562) / 64'd97703125;
    end
    return k[23:0];
  endfunction

  // Add one rounded tower term, saturating at the top of 32 bits
  function automatic logic [31:0] add_energy(logic [31:0] acc, logic signed [23:0] adc,
                                             logic [23:0] k);
    logic [63:0] term;
    logic [63:0] total;
    if (adc <= 0) return acc;
    term  = ({40'd0, adc} * {40'd0, k} + 64'h20_0000) >> 22;
    total = {32'd0, acc} + term;
    return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  function automatic void beam_offsets(output int ox, output int oy);
    int c;
    c  = (spot_case == 4'd0) ? 0 : int'(spot_case) - 1;
    ox = col_ofs[c % 5];
    oy = row_ofs[(c / 5) % 3];
  endfunction

  // Truncating bin; just below the low edge still counts as cell zero
  function automatic bit cell_of(int v, int count, output logic [4:0] idx);
    int q;
    idx = '0;
    if (v <= -CellPitch) return 1'b0;
    q = (v < 0) ? 0 : v / CellPitch;
    if (q >= count) return 1'b0;
    idx = q[4:0];
    return 1'b1;
  endfunction

  function automatic selection_t select_event(beat_t b);
    int          x1, y1, x2, y2, dx, dy, ox, oy;
    logic [4:0]  ax, ay, bx, by;
    bit          g1, g2, g3, g4;
    selection_t  s;
    x1 = b.c1x;
    y1 = b.c1y;
    x2 = b.c2x;
    y2 = b.c2y;
    dx = x1 - x2;
    dy = y1 - y2;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    s.passed = (dx <= match_limit) && (dy <= match_limit) &&
               (int'(b.preshower) >= pre_min) && (int'(b.muon) <= mu_max);
    beam_offsets(ox, oy);
    g1 = cell_of(x1 + ox + ces_pkg::GridOrigin, GridCols, ax);
    g2 = cell_of(y1 + oy + ces_pkg::GridOrigin, GridRows, ay);
    g3 = cell_of(x2 + ox + ces_pkg::GridOrigin, GridCols, bx);
    g4 = cell_of(y2 + oy + ces_pkg::GridOrigin, GridRows, by);
    s.in_grid = g1 && g2 && g3 && g4;
    s.cell_x  = s.in_grid ? bx : 5'd0;
    s.cell_y  = s.in_grid ? by : 5'd0;
    s.e_ceren = ceren_total;
    s.e_scint = scint_total;
    return s;
  endfunction

  // Advance the predictor by one accepted beat
  function automatic void absorb(beat_t b);
    if (b.op == ces_pkg::OP_TOWER) begin
      if (b.tower < NumTowers) begin
        ceren_total = add_energy(ceren_total, b.ceren, calib(1'b0, int'(b.tower)));
        scint_total = add_energy(scint_total, b.scint, calib(1'b1, int'(b.tower)));
      end
    end else begin
      expected_selections.insert(expected_selections.size(), select_event(b));
      ceren_total = '0;
      scint_total = '0;
    end
  endfunction

  // ---------------------------------------------------------------- beat builders

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Position that lands on shifted coordinate v under the given offset
  function automatic logic signed [15:0] place(int v, int ofs);
    return clamp16(v - ofs - ces_pkg::GridOrigin);
  endfunction

  function automatic beat_t make_tower(int idx, int ce, int sc);
    beat_t b;
    b.op        = ces_pkg::OP_TOWER;
    b.tower     = idx[5:0];
    b.ceren     = ce[23:0];
    b.scint     = sc[23:0];
    b.c1x       = 16'($urandom);
    b.c1y       = 16'($urandom);
    b.c2x       = 16'($urandom);
    b.c2y       = 16'($urandom);
    b.preshower = 12'($urandom);
    b.muon      = 12'($urandom);
    return b;
  endfunction

  // Event close; tower fields are junk the block must ignore
  function automatic beat_t make_close(int x1, int y1, int x2, int y2, int ps, int mu);
    beat_t b;
    b.op        = ces_pkg::OP_CLOSE;
    b.tower     = 6'($urandom);
    b.ceren     = 24'($urandom);
    b.scint     = 24'($urandom);
    b.c1x       = x1[15:0];
    b.c1y       = y1[15:0];
    b.c2x       = x2[15:0];
    b.c2y       = y2[15:0];
    b.preshower = ps[11:0];
    b.muon      = mu[11:0];
    return b;
  endfunction

  function automatic beat_t close_at(int vx1, int vy1, int vx2, int vy2, int ps, int mu);
    int ox, oy;
    beam_offsets(ox, oy);
    return make_close(place(vx1, ox), place(vy1, oy), place(vx2, ox), place(vy2, oy), ps, mu);
  endfunction

  function automatic int rand_adc();
    int mag;
    case ($urandom_range(0, 9))
      0: return -int'($urandom_range(0, 8388608));
      1: return int'($urandom) >>> 8;
      2: return MaxAdc;
      default: begin
        mag = $urandom_range(1, 23);
        return int'($urandom_range(1, (1 << mag) - 1));
      end
    endcase
  endfunction

  function automatic beat_t random_tower();
    int idx;
    idx = ($urandom_range(0, 9) == 0) ? int'($urandom_range(NumTowers, 63))
                                      : int'($urandom_range(0, NumTowers - 1));
    return make_tower(idx, rand_adc(), rand_adc());
  endfunction

  function automatic int grid_edge_v(int span);
    case ($urandom_range(0, 5))
      0: return -CellPitch;
      1: return -CellPitch + 1;
      2: return CellPitch - 1;
      3: return CellPitch;
      4: return span * CellPitch - 1;
      default: return span * CellPitch;
    endcase
  endfunction

  // Counter peak around a cut threshold, or anywhere
  function automatic int peak_near(int thr);
    int v;
    if ($urandom_range(0, 2) == 0) return int'($urandom_range(0, 4095));
    v = thr + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  function automatic beat_t random_close();
    int ox, oy, vx, vy, dx, dy, spread;
    if ($urandom_range(0, 9) < 2)
      return make_close($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    beam_offsets(ox, oy);
    vx = ($urandom_range(0, 9) == 0) ? grid_edge_v(GridCols)
                                     : int'($urandom_range(0, GridCols * CellPitch + 1280)) - 640;
    vy = ($urandom_range(0, 9) == 0) ? grid_edge_v(GridRows)
                                     : int'($urandom_range(0, GridRows * CellPitch + 1280)) - 640;
    spread = match_limit + 4;
    dx = int'($urandom_range(0, 2 * spread)) - spread;
    dy = int'($urandom_range(0, 2 * spread)) - spread;
    return make_close(place(vx + dx, ox), place(vy + dy, oy), place(vx, ox), place(vy, oy),
                      peak_near(pre_min), peak_near(mu_max));
  endfunction

  // ---------------------------------------------------------------- drivers

  // Send one beat in random bursts; valid stays up into the next beat of a burst
  task automatic send_beat(beat_t b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_operation      <= b.op;
    in_tower_index    <= b.tower;
    in_ceren_adc      <= b.ceren;
    in_scint_adc      <= b.scint;
    in_chamber1_x     <= b.c1x;
    in_chamber1_y     <= b.c1y;
    in_chamber2_x     <= b.c2x;
    in_chamber2_y     <= b.c2y;
    in_preshower_peak <= b.preshower;
    in_muon_peak      <= b.muon;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb(b);
    if (b.op == ces_pkg::OP_CLOSE || b.tower < NumTowers) accepted_items++;
  endtask

  // Drop valid and hold until every pending selection has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_selections.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles, block idle
  task automatic set_config(logic [11:0] spot_word, logic [11:0] limit, logic [11:0] pre,
                            logic [11:0] mu);
    cfg_we    <= 1'b1;
    cfg_index <= ces_pkg::CFG_BEAM_SPOT;
    cfg_wdata <= spot_word;
    @(posedge clk);
    cfg_index <= ces_pkg::CFG_MATCH_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_index <= ces_pkg::CFG_PRESHOWER;
    cfg_wdata <= pre;
    @(posedge clk);
    cfg_index <= ces_pkg::CFG_MUON;
    cfg_wdata <= mu;
    @(posedge clk);
    cfg_we <= 1'b0;
    spot_case   = spot_word[3:0];
    match_limit = int'(limit);
    pre_min     = int'(pre);
    mu_max      = int'(mu);
    @(posedge clk);
  endtask

  // Random events, mostly well formed, until the item budget is used
  task automatic run_random_events(int quota);
    int goal;
    int towers;
    goal = accepted_items + quota;
    while (accepted_items < goal) begin
      towers = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      repeat (towers) send_beat(random_tower());
      if ($urandom_range(0, 19) == 0) wait_drained();
      send_beat(random_close());
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_edges();
    send_beat(make_tower(0, MaxAdc, MaxAdc));
    send_beat(make_tower(NumTowers - 1, 1, 1));
    send_beat(make_tower(NumTowers, MaxAdc, MaxAdc));
    send_beat(make_tower(63, MaxAdc, MaxAdc));
    send_beat(make_tower(5, -8388608, 0));
    send_beat(make_tower(6, 0, -1));
    send_beat(close_at(1000, 1000, 1000, 1000, 4095, 0));
    // empty event at the far corners of the position range
    send_beat(make_close(-32768, 32767, 32767, -32768, 0, 4095));
    send_beat(make_tower(13, 4096, MaxAdc));
    // just inside the low edge, cuts exactly at threshold
    send_beat(close_at(-319, -319, -319, -319, 424, 38));
    send_beat(close_at(-320, -320, -320, -320, 423, 38));
    send_beat(close_at(9599, 6399, 9599, 6399, 4095, 39));
    send_beat(close_at(9600, 6400, 9599, 6399, 4095, 0));
    send_beat(close_at(9599, 6399, 9600, 6400, 4095, 0));
    // chamber difference exactly at and one past the limit
    send_beat(close_at(576, 63, 320, 319, 424, 38));
    send_beat(close_at(577, 62, 320, 319, 424, 38));
    wait_drained();
  endtask

  task automatic test_energy_saturation();
    repeat (720) send_beat(make_tower(18, MaxAdc, MaxAdc));
    send_beat(close_at(1000, 1000, 1000, 1000, 4095, 0));
    send_beat(make_tower(18, MaxAdc, MaxAdc));
    send_beat(random_close());
    wait_drained();
  endtask

  task automatic test_default_cuts();
    run_random_events(300);
  endtask

  task automatic test_open_cuts();
    set_config(12'd0, 12'd4095, 12'd0, 12'd4095);
    run_random_events(150);
  endtask

  task automatic test_tight_cuts();
    set_config(12'd15, 12'd0, 12'd4095, 12'd0);
    run_random_events(150);
  endtask

  task automatic test_random_settings();
    logic [11:0] spot_word;
    logic [11:0] limit;
    repeat (3) begin
      spot_word = 12'($urandom);
      limit     = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 600)) : 12'($urandom);
      set_config(spot_word, limit, 12'($urandom), 12'($urandom));
      run_random_events(100);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Receiver stalls: always ready, coin flip, or mostly stalled
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(20, 200);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each result beat with the oldest pending selection
  always @(posedge clk) begin
    selection_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_selections.size() == 0) begin
        report_mismatch("result beat with no event pending");
      end else begin
        want = expected_selections.pop_front();
        if (out_passed_cuts !== want.passed)
          report_mismatch($sformatf("passed_cuts %0b, want %0b", out_passed_cuts, want.passed));
        if (out_in_grid !== want.in_grid)
          report_mismatch($sformatf("in_grid %0b, want %0b", out_in_grid, want.in_grid));
        if (out_cell_x !== want.cell_x)
          report_mismatch($sformatf("cell_x %0d, want %0d", out_cell_x, want.cell_x));
        if (out_cell_y !== want.cell_y)
          report_mismatch($sformatf("cell_y %0d, want %0d", out_cell_y, want.cell_y));
        if (out_energy_ceren !== want.e_ceren)
          report_mismatch($sformatf("energy_ceren %0d, want %0d",
                                    out_energy_ceren, want.e_ceren));
        if (out_energy_scint !== want.e_scint)
          report_mismatch($sformatf("energy_scint %0d, want %0d",
                                    out_energy_scint, want.e_scint));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_energy_saturation();
    test_default_cuts();
    test_open_cuts();
    test_tight_cuts();
    test_random_settings();
    wait_drained();
    if (mismatches == 0) begin
      $display("tb_calorimeter_event_selector OK");
    end else begin
      $display("tb_calorimeter_event_selector NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("tb_calorimeter_event_selector NOT OK");
    $finish;
  end

endmodule
